[design/pmul_pkg.sv]
// Shared types and constants for the polynomial multiplier.
package pmul_pkg;

  localparam int COEF_W = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } pmul_state_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } mac_ctrl_t;

endpackage

[design/pmul_mac.sv]
// Multiply-accumulate pipeline: registered product, then wrapping accumulate.
module pmul_mac
  import pmul_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctrl_t         ctrl,
  input  logic [COEF_W-1:0] opnd_a,
  input  logic [COEF_W-1:0] opnd_b,
  output logic [COEF_W-1:0] acc,
  output logic              busy
);

  logic [COEF_W-1:0] prod;
  logic [2*COEF_W-1:0] prod_full;

  assign prod_full = opnd_a * opnd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_full[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (busy) begin
      acc <= acc + prod;
    end
  end

endmodule

[design/polynomial_multiplier.sv]
// Polynomial multiplier: coefficient stores, sequencer and output handshake.
// Load: one coefficient pair per cycle, stall low while loading.
// Product: each coefficient k accumulates its terms one at a time, then waits for the output handshake;
//   the 2n coefficients are produced in turn, limited by the single read port
//   of each store feeding one multiply-accumulate.
// No new pair is taken until the last product coefficient has gone.
// Synchronous reset clears the sequencer and pair count; stores are not cleared.
module polynomial_multiplier
  import pmul_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] product_coef,
  output logic               last_coef
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int KW = $clog2(2 * MAX_TERMS);
  localparam int XW = KW + 1;

  logic [COEF_W-1:0] store_a [MAX_TERMS];
  logic [COEF_W-1:0] store_b [MAX_TERMS];

  pmul_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] n, n_next;
  logic [KW-1:0] k, k_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] hi, hi_next;
  logic          issuing, issuing_next;
  logic          rd_valid;
  logic [COEF_W-1:0] rd_a, rd_b;
  logic [COEF_W-1:0] acc;
  logic          mac_busy;
  mac_ctrl_t     mac_ctrl;

  logic          in_take, out_take, room;
  logic [KW-1:0] k_sel;
  logic [CW-1:0] n_sel;
  logic [XW-1:0] kx, nx, lo_w, hi_w;
  logic [XW-1:0] b_addr_w;
  logic          start_coef, drained;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign room     = (count < CW'(MAX_TERMS));
  assign drained  = !issuing && !rd_valid && !mac_busy;

  // term range of the coefficient about to start
  assign kx   = XW'(k_sel);
  assign nx   = XW'(n_sel);
  assign lo_w = (kx >= nx) ? (kx - nx + XW'(1)) : '0;
  assign hi_w = (kx < nx) ? kx : (nx - XW'(1));

  assign b_addr_w = XW'(k) - XW'(idx);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_take && last_pair) state_next = ST_CALC;
      ST_CALC: if (drained) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_take) state_next = last_coef ? ST_LOAD : ST_CALC;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    count_next   = count;
    n_next       = n;
    k_next       = k;
    idx_next     = idx;
    hi_next      = hi;
    issuing_next = issuing;
    k_sel        = k + KW'(1);
    n_sel        = n;
    start_coef   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        n_sel = count + (room ? CW'(1) : CW'(0));
        k_sel = '0;
        if (in_take) begin
          count_next = n_sel;
          if (last_pair) begin
            count_next = '0;
            n_next     = n_sel;
            start_coef = 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (issuing) begin
          if (idx == hi) begin
            issuing_next = 1'b0;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_take && !last_coef) start_coef = 1'b1;
      end
      default: ;
    endcase
    if (start_coef) begin
      k_next       = k_sel;
      idx_next     = lo_w[CW-1:0];
      hi_next      = hi_w[CW-1:0];
      issuing_next = (lo_w <= hi_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      issuing  <= issuing_next;
      rd_valid <= (state == ST_CALC) && issuing;
    end
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    k   <= k_next;
    idx <= idx_next;
    hi  <= hi_next;
  end

  always_ff @(posedge clk) begin
    if (in_take && room) begin
      store_a[count[AW-1:0]] <= coef_a;
      store_b[count[AW-1:0]] <= coef_b;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CALC) && issuing) begin
      rd_a <= store_a[idx[AW-1:0]];
      rd_b <= store_b[b_addr_w[AW-1:0]];
    end
  end

  assign mac_ctrl.valid = rd_valid;
  assign mac_ctrl.clear = start_coef;

  pmul_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .opnd_a (rd_a),
    .opnd_b (rd_b),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assign in_stall     = (state != ST_LOAD);
  assign out_valid    = (state == ST_EMIT);
  assign product_coef = acc;
  assign last_coef    = (XW'(k) == ((XW'(n) << 1) - XW'(1)));

endmodule
